// ===== rtl/core/fet_pkg.sv =====
package fet_pkg;

  // table geometry and block size; BLOCK_BYTES must be a power of two
  localparam int TABLE_ENTRIES   = 16;
  localparam int BLOCK_BYTES     = 4;
  localparam int NAME_BYTES      = 8;
  localparam int RESERVED_BLOCKS = 64;

  localparam int NAME_W  = 64;
  localparam int WORD_W  = 32;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int BLOCK_LOG = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 0;

  localparam logic [WORD_W-1:0] BLOCK_MASK  = WORD_W'(BLOCK_BYTES - 1);
  localparam logic [WORD_W-1:0] RESET_BLOCKS = WORD_W'(RESERVED_BLOCKS);
  localparam logic [WORD_W-1:0] RESET_FREE  = WORD_W'(RESERVED_BLOCKS * BLOCK_BYTES);

  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PRESENT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [WORD_W-1:0] size;
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] blocks;
  } entry_t;

  typedef struct packed {
    logic match_en;
    logic commit;
    logic create_en;
    logic delete_en;
  } cell_ctl_t;

  // name ends at its first zero byte or after NAME_BYTES bytes
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] key);
    logic [NAME_W-1:0] r;
    logic ended;
    r = '0;
    ended = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (key[8*k +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        r[8*k +: 8] = key[8*k +: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] round_block(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] s;
    s = v + BLOCK_MASK;
    return s & ~BLOCK_MASK;
  endfunction

  function automatic logic [WORD_W-1:0] block_count(input logic [WORD_W-1:0] size);
    logic [WORD_W:0] s;
    s = {1'b0, size} + {1'b0, BLOCK_MASK};
    return WORD_W'(s >> BLOCK_LOG);
  endfunction

endpackage

// ===== rtl/core/fet_cell.sv =====
module fet_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  fet_pkg::cell_ctl_t         ctl,
  input  logic [fet_pkg::NAME_W-1:0] key,
  input  fet_pkg::entry_t            wr_entry,
  input  fet_pkg::entry_t            upper_entry,
  input  logic                       is_last,
  input  logic                       above_in,
  input  logic                       free_in,
  input  logic                       reach_in,
  output logic                       above_out,
  output logic                       free_out,
  output logic                       reach_out,
  output fet_pkg::entry_t            entry,
  output logic                       hit,
  output logic                       first_free,
  output logic                       last_hit
);
  import fet_pkg::*;

  logic [NAME_W-1:0] slot_name;
  logic [WORD_W-1:0] slot_size;
  logic [WORD_W-1:0] slot_start;
  logic [WORD_W-1:0] slot_blocks;
  logic              match;
  logic              used;
  logic              reach_here;
  logic              do_write;
  logic              do_shift;
  logic              do_clear;
  entry_t            entry_next;

  assign entry = '{name: slot_name, size: slot_size, start: slot_start, blocks: slot_blocks};
  assign used  = (slot_start != '0);

  // highest match wins: the token runs down from the top cell
  assign above_out  = above_in | match;
  assign hit        = match & ~above_in;
  // lowest free slot wins: the token runs up from cell zero
  assign free_out   = free_in | ~used;
  assign first_free = ~used & ~free_in;
  // compaction front runs up from the deleted slot while slots are used
  assign reach_here = hit | reach_in;
  assign reach_out  = reach_here & used;
  assign last_hit   = hit & (is_last | (upper_entry.start == '0));

  always_comb begin
    do_write = ctl.commit & ctl.create_en & first_free;
    do_shift = ctl.commit & ctl.delete_en & reach_here & used & ~is_last;
    do_clear = ctl.commit & ctl.delete_en & reach_here & (~used | is_last);
    entry_next = entry;
    if (do_write) begin
      entry_next = wr_entry;
    end else if (do_shift) begin
      entry_next = upper_entry;
    end else if (do_clear) begin
      entry_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_start <= '0;
    end else begin
      slot_start <= entry_next.start;
    end
  end

  always_ff @(posedge clk) begin
    slot_name   <= entry_next.name;
    slot_size   <= entry_next.size;
    slot_blocks <= entry_next.blocks;
    if (ctl.match_en) begin
      match <= used && (slot_name == key);
    end
  end

endmodule

// ===== rtl/core/file_entry_table_unit.sv =====
// channel  direction  handshake            fields
// in       to block   in_valid / in_stall  mode, name_key, file_size, start_byte
// out      from block out_valid/out_stall  status, entry_index, entry_size,
//                                          entry_start, file_count,
//                                          blocks_in_use, free_pointer
//
// each word passes a compare state, in which every cell matches its name, then
// an update state, in which the priority and compaction tokens ripple along the
// row of cells and the table and totals are written.
// the next word can be taken in the update state, while the last one is written.
// reset empties every slot and loads the reserved blocks and the free pointer.
// a stalled result holds the update state until the output register frees.
module file_entry_table_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fet_pkg::MODE_W-1:0]  mode,
  input  logic [fet_pkg::NAME_W-1:0]  name_key,
  input  logic [fet_pkg::WORD_W-1:0]  file_size,
  input  logic [fet_pkg::WORD_W-1:0]  start_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fet_pkg::STAT_W-1:0]  status,
  output logic [fet_pkg::INDEX_W-1:0] entry_index,
  output logic [fet_pkg::WORD_W-1:0]  entry_size,
  output logic [fet_pkg::WORD_W-1:0]  entry_start,
  output logic [fet_pkg::COUNT_W-1:0] file_count,
  output logic [fet_pkg::WORD_W-1:0]  blocks_in_use,
  output logic [fet_pkg::WORD_W-1:0]  free_pointer
);
  import fet_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic              accept;
  logic              fire;

  logic              op_create;
  logic              op_delete;
  logic [NAME_W-1:0] op_key;
  logic [WORD_W-1:0] op_size;
  logic [WORD_W-1:0] op_start;
  logic [WORD_W-1:0] op_blocks;
  logic [WORD_W-1:0] op_round_end;

  // a create with a zero start counts a file but leaves its slot free,
  // so the count can run past the table size and wraps at its width
  logic [COUNT_W-1:0] files_held;
  logic [COUNT_W-1:0] files_held_next;
  logic [WORD_W-1:0] blocks_used;
  logic [WORD_W-1:0] blocks_used_next;
  logic [WORD_W-1:0] next_free_byte;
  logic [WORD_W-1:0] next_free_byte_next;

  cell_ctl_t         ctl;
  entry_t            wr_entry;
  entry_t            cell_entry [TABLE_ENTRIES];
  logic [TABLE_ENTRIES:0] above_chain;
  logic [TABLE_ENTRIES:0] free_chain;
  logic [TABLE_ENTRIES:0] reach_chain;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [TABLE_ENTRIES-1:0] free_vec;
  logic [TABLE_ENTRIES-1:0] last_vec;

  logic              any_hit;
  logic              any_free;
  logic              create_ok;
  logic              delete_ok;
  entry_t            hit_entry;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [WORD_W-1:0] res_size;
  logic [WORD_W-1:0] res_start;

  assign fire     = (state == ST_EXEC) && (!out_valid || !out_stall);
  assign in_stall = !((state == ST_IDLE) || fire);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_MATCH;
      ST_MATCH: state_next = ST_EXEC;
      ST_EXEC: begin
        if (accept) begin
          state_next = ST_MATCH;
        end else if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // word capture; mode three behaves as a search
  always_ff @(posedge clk) begin
    if (accept) begin
      op_create    <= (mode == MODE_CREATE);
      op_delete    <= (mode == MODE_DELETE);
      op_key       <= norm_name(name_key);
      op_size      <= file_size;
      op_start     <= start_byte;
      op_blocks    <= block_count(file_size);
      op_round_end <= round_block(start_byte + file_size);
    end
  end

  assign ctl = '{match_en:  (state == ST_MATCH),
                 commit:    fire,
                 create_en: op_create && !any_hit,
                 delete_en: op_delete};
  assign wr_entry = '{name: op_key, size: op_size, start: op_start, blocks: op_blocks};

  assign above_chain[TABLE_ENTRIES] = 1'b0;
  assign free_chain[0]  = 1'b0;
  assign reach_chain[0] = 1'b0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t upper;
    if (i == TABLE_ENTRIES - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_entry[i+1];
    end
    fet_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key         (op_key),
      .wr_entry    (wr_entry),
      .upper_entry (upper),
      .is_last     (i == TABLE_ENTRIES - 1),
      .above_in    (above_chain[i+1]),
      .free_in     (free_chain[i]),
      .reach_in    (reach_chain[i]),
      .above_out   (above_chain[i]),
      .free_out    (free_chain[i+1]),
      .reach_out   (reach_chain[i+1]),
      .entry       (cell_entry[i]),
      .hit         (hit_vec[i]),
      .first_free  (free_vec[i]),
      .last_hit    (last_vec[i])
    );
  end

  assign any_hit   = above_chain[0];
  assign any_free  = free_chain[TABLE_ENTRIES];
  assign create_ok = op_create && !any_hit && any_free;
  assign delete_ok = op_delete && any_hit;

  // one-hot select of the matched slot and the free slot
  always_comb begin
    hit_entry = '0;
    hit_idx   = '0;
    free_idx  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_entry = hit_entry | (hit_vec[i] ? cell_entry[i] : '0);
      hit_idx   = hit_idx | (hit_vec[i] ? IDX_W'(i) : '0);
      free_idx  = free_idx | (free_vec[i] ? IDX_W'(i) : '0);
    end
  end

  always_comb begin
    files_held_next     = files_held;
    blocks_used_next    = blocks_used;
    next_free_byte_next = next_free_byte;
    res_status = STAT_OK;
    res_idx    = '0;
    res_size   = '0;
    res_start  = '0;
    if (op_create) begin
      if (any_hit) begin
        res_status = STAT_PRESENT;
      end else if (!any_free) begin
        res_status = STAT_FULL;
      end else begin
        res_idx   = free_idx;
        res_size  = op_size;
        res_start = op_start;
        files_held_next  = files_held + COUNT_W'(1);
        blocks_used_next = blocks_used + op_blocks;
        if (op_start == next_free_byte) begin
          next_free_byte_next = op_round_end;
        end
      end
    end else if (!any_hit) begin
      res_status = STAT_NOT_FOUND;
    end else begin
      res_idx   = hit_idx;
      res_size  = hit_entry.size;
      res_start = hit_entry.start;
      if (op_delete) begin
        files_held_next  = files_held - COUNT_W'(1);
        blocks_used_next = blocks_used - hit_entry.blocks;
        if (last_vec != '0) begin
          next_free_byte_next = round_block(hit_entry.start);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      files_held     <= '0;
      blocks_used    <= RESET_BLOCKS;
      next_free_byte <= RESET_FREE;
      out_valid      <= 1'b0;
    end else begin
      if (fire) begin
        files_held     <= files_held_next;
        blocks_used    <= blocks_used_next;
        next_free_byte <= next_free_byte_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status        <= res_status;
      entry_index   <= INDEX_W'(res_idx);
      entry_size    <= res_size;
      entry_start   <= res_start;
      file_count    <= files_held_next;
      blocks_in_use <= blocks_used_next;
      free_pointer  <= next_free_byte_next;
    end
  end

  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> ($onehot0(hit_vec) && $onehot0(free_vec)))
    else $error("more than one slot selected");

  a_no_commit_on_fail: assert property (@(posedge clk) disable iff (rst)
    (fire && !create_ok && !delete_ok) |=> $stable(files_held) && $stable(blocks_used))
    else $error("totals changed by a refused word");

  a_accept_to_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MATCH))
    else $error("accepted word not matched next cycle");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STAT_OK)) |-> (entry_index == '0))
    else $error("index set on a failed word");

endmodule
